### rtl/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared widths, command and status codes, and parameter defaults.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int CAPACITY_DEF        = 16;
   localparam int PAYLOAD_WIDTH_DEF   = 32;
   localparam int PRIORITY_LEVELS_DEF = 5;

   localparam int CMD_WIDTH    = 2;
   localparam int PRIO_WIDTH   = 3;
   localparam int STATUS_WIDTH = 2;

   localparam logic [CMD_WIDTH-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_CLEAR   = 2'd2;

   localparam logic [STATUS_WIDTH-1:0] STAT_OK    = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STAT_FULL  = 2'd2;

endpackage
`default_nettype wire

### rtl/spq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module spq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/stable_priority_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stable priority queue
// Bounded queue ordered by priority level, first in, first out within a level.
// ----------------------------------------------------------------------------
// Each command is taken when start is high and busy is low. Busy is then high
// for one cycle, while the payload and link RAMs return their registered read
// data. At the end of that cycle the result is registered onto the rsp_ ports,
// where it is shown with rsp_strobe high for one cycle. No new command is taken
// while busy is high. Entries live in a payload RAM, chained per level through
// a link RAM, with freed slots kept on a free list. The receiver cannot stall,
// so every result must be captured in the cycle it is shown.
// No clearing pass is needed after reset or after a clear command.
module stable_priority_queue #(
   parameter int CAPACITY        = spq_pkg::CAPACITY_DEF,
   parameter int PAYLOAD_WIDTH   = spq_pkg::PAYLOAD_WIDTH_DEF,
   parameter int PRIORITY_LEVELS = spq_pkg::PRIORITY_LEVELS_DEF,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [spq_pkg::CMD_WIDTH-1:0]    req_cmd,
   input  wire logic [spq_pkg::PRIO_WIDTH-1:0]   req_priority_req,
   input  wire logic [PAYLOAD_WIDTH-1:0]         req_payload,
   output logic                                  rsp_strobe,
   output logic      [spq_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic      [spq_pkg::PRIO_WIDTH-1:0]   rsp_out_priority,
   output logic      [PAYLOAD_WIDTH-1:0]         rsp_out_payload,
   output logic      [CW-1:0]                    rsp_count
);

   localparam int SW = $clog2(CAPACITY);
   localparam int LW = $clog2(PRIORITY_LEVELS);
   localparam int PRW = spq_pkg::PRIO_WIDTH;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_WORK = 1'b1;

   localparam logic [1:0] OP_NONE = 2'd0;
   localparam logic [1:0] OP_ENQ  = 2'd1;
   localparam logic [1:0] OP_DEQ  = 2'd2;

   logic                             state_ff, state_in;
   logic [1:0]                       op_ff, op_in;
   logic [spq_pkg::STATUS_WIDTH-1:0] stat_ff, stat_in;
   logic [LW-1:0]                    lvl_op_ff, lvl_op_in;
   logic [SW-1:0]                    slot_op_ff, slot_op_in;
   logic                             from_free_ff, from_free_in;
   logic [CW-1:0]                    occ_ff, occ_in;
   logic [CW-1:0]                    fill_ff, fill_in;
   logic [SW-1:0]                    free_head_ff, free_head_in;
   logic [CW-1:0]                    lcnt_ff [PRIORITY_LEVELS];
   logic [CW-1:0]                    lcnt_in [PRIORITY_LEVELS];
   logic [SW-1:0]                    head_ff [PRIORITY_LEVELS];
   logic [SW-1:0]                    head_in [PRIORITY_LEVELS];
   logic [SW-1:0]                    tail_ff [PRIORITY_LEVELS];
   logic [SW-1:0]                    tail_in [PRIORITY_LEVELS];

   logic                             strobe_ff, strobe_in;
   logic [spq_pkg::STATUS_WIDTH-1:0] status_ff, status_in;
   logic [PRW-1:0]                   prio_ff, prio_in;
   logic [PAYLOAD_WIDTH-1:0]         payload_ff, payload_in;
   logic [CW-1:0]                    count_ff, count_in;

   logic                     accept;
   logic                     is_enq, is_deq, is_clr;
   logic                     full, empty, use_free;
   logic [LW-1:0]            enq_lvl, deq_lvl, sel_lvl;
   logic [SW-1:0]            new_slot, sel_head, sel_tail;
   logic [CW-1:0]            sel_cnt;

   logic                     data_we, data_re;
   logic [PAYLOAD_WIDTH-1:0] data_rd;
   logic                     link_we, link_re;
   logic [SW-1:0]            link_waddr, link_wdata, link_raddr, link_rd;

   assign busy   = (state_ff == ST_WORK);
   assign accept = start && !busy;
   assign is_enq = (req_cmd == spq_pkg::CMD_ENQUEUE);
   assign is_deq = (req_cmd == spq_pkg::CMD_DEQUEUE);
   assign is_clr = (req_cmd == spq_pkg::CMD_CLEAR);
   assign full   = (occ_ff == CW'(CAPACITY));
   assign empty  = (occ_ff == '0);
   assign use_free = (occ_ff < fill_ff);
   assign new_slot = use_free ? free_head_ff : fill_ff[SW-1:0];

   always_comb begin
      if (32'(req_priority_req) >= 32'(PRIORITY_LEVELS - 1)) begin
         enq_lvl = LW'(PRIORITY_LEVELS - 1);
      end else begin
         enq_lvl = LW'(req_priority_req);
      end
   end

   always_comb begin
      deq_lvl = '0;
      for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
         if (lcnt_ff[i] != '0) begin
            deq_lvl = LW'(i);
         end
      end
   end

   assign sel_lvl  = is_enq ? enq_lvl : deq_lvl;
   assign sel_head = head_ff[sel_lvl];
   assign sel_tail = tail_ff[sel_lvl];
   assign sel_cnt  = lcnt_ff[sel_lvl];

   assign data_we = accept && is_enq && !full;
   assign data_re = accept && is_deq && !empty;

   assign link_we = (accept && is_enq && !full && sel_cnt != '0)
                 || (busy && op_ff == OP_DEQ);
   assign link_waddr = busy ? slot_op_ff : sel_tail;
   assign link_wdata = busy ? free_head_ff : new_slot;
   assign link_re    = accept;
   assign link_raddr = is_enq ? free_head_ff : sel_head;

   spq_ram #(
      .WIDTH (PAYLOAD_WIDTH),
      .DEPTH (CAPACITY)
   ) u_data_ram (
      .clock   (clock),
      .wr_en   (data_we),
      .wr_addr (new_slot),
      .wr_data (req_payload),
      .rd_en   (data_re),
      .rd_addr (sel_head),
      .rd_data (data_rd)
   );

   spq_ram #(
      .WIDTH (SW),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (link_we),
      .wr_addr (link_waddr),
      .wr_data (link_wdata),
      .rd_en   (link_re),
      .rd_addr (link_raddr),
      .rd_data (link_rd)
   );

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      stat_in      = stat_ff;
      lvl_op_in    = lvl_op_ff;
      slot_op_in   = slot_op_ff;
      from_free_in = from_free_ff;
      occ_in       = occ_ff;
      fill_in      = fill_ff;
      free_head_in = free_head_ff;
      lcnt_in      = lcnt_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      strobe_in    = 1'b0;
      status_in    = status_ff;
      prio_in      = prio_ff;
      payload_in   = payload_ff;
      count_in     = count_ff;

      if (accept) begin
         state_in = ST_WORK;
         op_in    = OP_NONE;
         stat_in  = spq_pkg::STAT_OK;
         if (is_enq) begin
            if (full) begin
               stat_in = spq_pkg::STAT_FULL;
            end else begin
               op_in             = OP_ENQ;
               from_free_in      = use_free;
               occ_in            = occ_ff + 1'b1;
               lcnt_in[enq_lvl]  = sel_cnt + 1'b1;
               tail_in[enq_lvl]  = new_slot;
               if (sel_cnt == '0) begin
                  head_in[enq_lvl] = new_slot;
               end
               if (!use_free) begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end else if (is_deq) begin
            if (empty) begin
               stat_in = spq_pkg::STAT_EMPTY;
            end else begin
               op_in            = OP_DEQ;
               lvl_op_in        = deq_lvl;
               slot_op_in       = sel_head;
               occ_in           = occ_ff - 1'b1;
               lcnt_in[deq_lvl] = sel_cnt - 1'b1;
            end
         end else if (is_clr) begin
            occ_in  = '0;
            fill_in = '0;
            for (int i = 0; i < PRIORITY_LEVELS; i++) begin
               lcnt_in[i] = '0;
            end
         end
      end

      if (busy) begin
         state_in   = ST_IDLE;
         strobe_in  = 1'b1;
         status_in  = stat_ff;
         prio_in    = '0;
         payload_in = '0;
         count_in   = occ_ff;
         case (op_ff)
            OP_ENQ: begin
               if (from_free_ff) begin
                  free_head_in = link_rd;
               end
            end
            OP_DEQ: begin
               head_in[lvl_op_ff] = link_rd;
               free_head_in       = slot_op_ff;
               prio_in            = PRW'(lvl_op_ff);
               payload_in         = data_rd;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         occ_ff    <= '0;
         fill_ff   <= '0;
         strobe_ff <= 1'b0;
         for (int i = 0; i < PRIORITY_LEVELS; i++) begin
            lcnt_ff[i] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         occ_ff    <= occ_in;
         fill_ff   <= fill_in;
         strobe_ff <= strobe_in;
         lcnt_ff   <= lcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      stat_ff      <= stat_in;
      lvl_op_ff    <= lvl_op_in;
      slot_op_ff   <= slot_op_in;
      from_free_ff <= from_free_in;
      free_head_ff <= free_head_in;
      head_ff      <= head_in;
      tail_ff      <= tail_in;
      status_ff    <= status_in;
      prio_ff      <= prio_in;
      payload_ff   <= payload_in;
      count_ff     <= count_in;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_priority = prio_ff;
   assign rsp_out_payload  = payload_ff;
   assign rsp_count        = count_ff;

endmodule
`default_nettype wire

### rtl/spq_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stable priority queue checker
// Port-level assertions on command timing and result consistency.
// ----------------------------------------------------------------------------
module spq_checker #(
   parameter int CAPACITY      = spq_pkg::CAPACITY_DEF,
   parameter int PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEF,
   localparam int CW = $clog2(CAPACITY + 1)
) (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic                             rsp_strobe,
   input wire logic [spq_pkg::STATUS_WIDTH-1:0] rsp_status,
   input wire logic [PAYLOAD_WIDTH-1:0]         rsp_out_payload,
   input wire logic [CW-1:0]                    rsp_count
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("Accepted item did not raise busy.");

   a_result_timing: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("Result did not follow two cycles after the item.");

   a_busy_single: assert property (@(posedge clock) disable iff (reset)
      busy |=> (!busy && rsp_strobe))
      else $error("Busy lasted longer than one cycle.");

   a_result_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ((32'(rsp_count) <= CAPACITY)
         && (rsp_status == spq_pkg::STAT_OK || rsp_status == spq_pkg::STAT_EMPTY
             || rsp_status == spq_pkg::STAT_FULL)))
      else $error("Result count or status out of range.");

   a_empty_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == spq_pkg::STAT_EMPTY)
         |-> (rsp_count == '0 && rsp_out_payload == '0))
      else $error("Empty result with nonzero count or payload.");

endmodule

bind stable_priority_queue spq_checker #(
   .CAPACITY      (CAPACITY),
   .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
) u_spq_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_out_payload (rsp_out_payload),
   .rsp_count       (rsp_count)
);
`default_nettype wire
